// ===== hw/rtl/u8d_pkg.sv =====
package u8d_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CP_W        = 31;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TRAIL    = 3'd1,
    ERR_STRAY    = 3'd2,
    ERR_FEFF     = 3'd3,
    ERR_OVERLONG = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    KIND_ASCII = 2'd0,
    KIND_CONT  = 2'd1,
    KIND_LEAD  = 2'd2,
    KIND_FEFF  = 2'd3
  } kind_e;

  // Classified byte as it travels from front to back.
  typedef struct packed {
    kind_e      kind;
    logic [2:0] seq_len;  // lead bytes only
    logic [6:0] payload;  // ascii: 7 bits, cont: low 6, lead: masked bits
  } word_t;

  // Least legal value for each sequence length.
  function automatic logic [CP_W-1:0] least_value(input logic [2:0] len);
    logic [CP_W-1:0] v;
    unique case (len)
      3'd2:    v = CP_W'(32'h0000_0080);
      3'd3:    v = CP_W'(32'h0000_0800);
      3'd4:    v = CP_W'(32'h0001_0000);
      3'd5:    v = CP_W'(32'h0020_0000);
      3'd6:    v = CP_W'(32'h0400_0000);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/u8d_front.sv =====
module u8d_front import u8d_pkg::*; (
  input  logic [7:0] data_byte_i,
  output word_t      word_o
);

  always_comb begin
    word_o.seq_len = 3'd0;
    word_o.payload = 7'd0;
    priority if (data_byte_i < 8'h80) begin
      word_o.kind    = KIND_ASCII;
      word_o.payload = data_byte_i[6:0];
    end else if (data_byte_i < 8'hC0) begin
      word_o.kind    = KIND_CONT;
      word_o.payload = {1'b0, data_byte_i[5:0]};
    end else if (data_byte_i >= 8'hFE) begin
      word_o.kind    = KIND_FEFF;
    end else if (data_byte_i < 8'hE0) begin
      word_o.kind    = KIND_LEAD;
      word_o.seq_len = 3'd2;
      word_o.payload = {2'b0, data_byte_i[4:0]};
    end else if (data_byte_i < 8'hF0) begin
      word_o.kind    = KIND_LEAD;
      word_o.seq_len = 3'd3;
      word_o.payload = {3'b0, data_byte_i[3:0]};
    end else if (data_byte_i < 8'hF8) begin
      word_o.kind    = KIND_LEAD;
      word_o.seq_len = 3'd4;
      word_o.payload = {4'b0, data_byte_i[2:0]};
    end else if (data_byte_i < 8'hFC) begin
      word_o.kind    = KIND_LEAD;
      word_o.seq_len = 3'd5;
      word_o.payload = {5'b0, data_byte_i[1:0]};
    end else begin
      word_o.kind    = KIND_LEAD;
      word_o.seq_len = 3'd6;
      word_o.payload = {6'b0, data_byte_i[0]};
    end
  end

endmodule

// ===== hw/rtl/u8d_queue.sv =====
module u8d_queue import u8d_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  word_t word_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output word_t word_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  word_t           slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign word_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

// ===== hw/rtl/u8d_back.sv =====
module u8d_back import u8d_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  word_t           word_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [CP_W-1:0] code_point_o,
  output err_e            error_code_o
);

  logic [CP_W-1:0] partial_q, partial_d, shifted;
  logic [2:0]      rem_q, rem_d, len_q, len_d;
  logic            out_valid_q, out_valid_d;
  logic [CP_W-1:0] cp_q, cp_d;
  err_e            err_q, err_d;
  logic            emit;
  logic            take;

  // Output register frees up when empty or when its word leaves this cycle.
  assign pop_o = !out_valid_q || !out_stall_i;
  assign take  = pop_o && valid_i;

  assign shifted = {partial_q[CP_W-7:0], word_i.payload[5:0]};

  always_comb begin
    partial_d = partial_q;
    rem_d     = rem_q;
    len_d     = len_q;
    emit      = 1'b0;
    cp_d      = '0;
    err_d     = ERR_NONE;
    if (take) begin
      if (rem_q == 3'd0) begin
        unique case (word_i.kind)
          KIND_ASCII: begin
            emit = 1'b1;
            cp_d = CP_W'(word_i.payload);
          end
          KIND_CONT: begin
            emit  = 1'b1;
            err_d = ERR_STRAY;
          end
          KIND_FEFF: begin
            emit  = 1'b1;
            err_d = ERR_FEFF;
          end
          KIND_LEAD: begin
            partial_d = CP_W'(word_i.payload);
            len_d     = word_i.seq_len;
            rem_d     = word_i.seq_len - 3'd1;
          end
          default: ;
        endcase
      end else if (word_i.kind != KIND_CONT) begin
        emit      = 1'b1;
        err_d     = ERR_TRAIL;
        partial_d = '0;
        rem_d     = 3'd0;
        len_d     = 3'd0;
      end else begin
        partial_d = shifted;
        rem_d     = rem_q - 3'd1;
        if (rem_q == 3'd1) begin
          emit      = 1'b1;
          partial_d = '0;
          len_d     = 3'd0;
          if (shifted < least_value(len_q)) begin
            err_d = ERR_OVERLONG;
          end else begin
            cp_d = shifted;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      rem_q       <= 3'd0;
      len_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      partial_q   <= partial_d;
      rem_q       <= rem_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      cp_q  <= cp_d;
      err_q <= err_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign error_code_o = err_q;

endmodule

// ===== hw/rtl/utf8_byte_stream_decoder.sv =====
// UTF-8 decoder for the original six-byte form: one byte word in, at most one
// word out per byte (a code point of up to 31 bits and an error code). It
// accepts a byte every cycle while the byte queue is not full; a result passes
// through the byte queue and then the output register before it appears.
// Errors: 1 bad trailing byte, 2 continuation byte in lead position, 3 lead
// byte FE/FF, 4 overlong encoding; the code point is zero on error and the
// offending byte is dropped. An unfinished sequence produces nothing.
module utf8_byte_stream_decoder import u8d_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [CP_W-1:0] code_point_o,
  output logic [2:0]      error_code_o
);

  word_t front_word, queue_word;
  logic  queue_full, queue_valid, back_pop;
  err_e  err;

  // Front: classify each byte as it arrives.
  u8d_front u_front (
    .data_byte_i (data_byte_i),
    .word_o      (front_word)
  );

  // Short queue decouples input stall from output stall.
  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .word_i  (front_word),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .word_o  (queue_word)
  );

  assign in_stall_o = queue_full;

  // Back: sequence tracking, overlong check, output register.
  u8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (queue_valid),
    .word_i       (queue_word),
    .pop_o        (back_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .error_code_o (err)
  );

  assign error_code_o = err;

endmodule

// ===== hw/rtl/u8d_checker.sv =====
module u8d_checker import u8d_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [CP_W-1:0] code_point_o,
  input logic [2:0]      error_code_o
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_point_o)
      && $stable(error_code_o))
    else $error("stalled result changed");

  // Error results carry a zero code point.
  a_err_zero_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ERR_NONE) |-> code_point_o == '0)
    else $error("error result with nonzero code point");

  // Only defined error codes leave the block.
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_code_o <= ERR_OVERLONG)
    else $error("undefined error code");

  // Input stall only rises once a byte has been taken.
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose with no byte taken");

  // Nothing comes out the cycle after reset releases.
  a_reset_quiet: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .code_point_o (code_point_o),
  .error_code_o (error_code_o)
);

// ===== tb/tb_utf8_byte_stream_decoder.sv =====
`timescale 1ns / 1ps

module tb_utf8_byte_stream_decoder;
  import u8d_pkg::*;

  localparam int unsigned NUM_DIR      = 23;      // directed table rows
  localparam int unsigned PHASE_BYTES  = 190;     // least random bytes per phase
  localparam int unsigned HOLD_CYCLES  = 64;      // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 8;       // extra wait for stray words
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_SHOWN    = 10;

  // One decoded character (or error) as the block should report it.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    err_e            err;
  } char_t;

  // Directed row: a byte, plus a typed-in result where it is obvious.
  typedef struct packed {
    logic [7:0]      data;
    logic            typed;
    logic [CP_W-1:0] cp;
    err_e            err;
  } row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [7:0]      data_byte_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [CP_W-1:0] code_point_o;
  logic [2:0]      error_code_o;

  utf8_byte_stream_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .error_code_o (error_code_o)
  );

  // Decoder shadow state: gathered payload, trailing bytes left, seq length.
  logic [CP_W-1:0] seq_value = '0;
  logic [2:0]      seq_left  = '0;
  logic [2:0]      seq_len   = '0;

  char_t      want_chars[$];   // characters the block still owes us
  logic [7:0] byte_q[$];       // random stream waiting to be sent
  row_t       dir_rows [NUM_DIR];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  bit          squeeze_go = 1'b0;
  logic        hold_off;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard stop: a hung handshake or a missing result ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Shadow decoder: one byte in, at most one character out.
  function automatic void decode_byte(input logic [7:0] b, output bit has,
                                      output logic [CP_W-1:0] cp, output err_e err);
    logic [2:0]      len;
    logic [CP_W-1:0] least;
    has = 1'b0;
    cp  = '0;
    err = ERR_NONE;
    if (seq_left == 3'd0) begin
      if (b < 8'h80) begin
        has = 1'b1;
        cp  = CP_W'(b);
      end else if (b < 8'hC0) begin
        // continuation byte with no open sequence
        has = 1'b1;
        err = ERR_STRAY;
      end else if (b >= 8'hFE) begin
        // never a legal lead, flagged right away
        has = 1'b1;
        err = ERR_FEFF;
      end else begin
        if (b < 8'hE0)      len = 3'd2;
        else if (b < 8'hF0) len = 3'd3;
        else if (b < 8'hF8) len = 3'd4;
        else if (b < 8'hFC) len = 3'd5;
        else                len = 3'd6;
        // lead keeps 7-len payload bits
        seq_value = CP_W'(b & (8'h7F >> len));
        seq_len   = len;
        seq_left  = len - 3'd1;
      end
    end else if (b[7:6] != 2'b10) begin
      // broken sequence: byte is dropped, not reused as a lead
      seq_value = '0;
      seq_left  = '0;
      seq_len   = '0;
      has = 1'b1;
      err = ERR_TRAIL;
    end else begin
      seq_value = {seq_value[CP_W-7:0], b[5:0]};
      seq_left  = seq_left - 3'd1;
      if (seq_left == 3'd0) begin
        case (seq_len)
          3'd2:    least = CP_W'(32'h0000_0080);
          3'd3:    least = CP_W'(32'h0000_0800);
          3'd4:    least = CP_W'(32'h0001_0000);
          3'd5:    least = CP_W'(32'h0020_0000);
          3'd6:    least = CP_W'(32'h0400_0000);
          default: least = '0;
        endcase
        has = 1'b1;
        if (seq_value < least) err = ERR_OVERLONG;
        else                   cp  = seq_value;
        seq_value = '0;
        seq_left  = '0;
        seq_len   = '0;
      end
    end
  endfunction

  // Offer one byte word; on acceptance record what it should produce.
  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input logic [CP_W-1:0] t_cp, input err_e t_err);
    bit              has;
    logic [CP_W-1:0] cp;
    err_e            err;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, has, cp, err);
    if (typed) begin
      // obvious rows carry their own answer
      has = 1'b1;
      cp  = t_cp;
      err = t_err;
    end
    if (has) want_chars.push_back('{cp: cp, err: err});
    @(negedge clk_i);
  endtask

  // Queue a random chunk of bytes. Mostly well-formed sequences with random
  // payload, the rest broken sequences, stray bytes, FE/FF and noise.
  task automatic build_chunk();
    int unsigned     pick, len, nbits, k, good;
    logic [31:0]     cp;
    logic [7:0]      lead;
    pick = $urandom_range(99);
    if (pick < 65) begin
      len = $urandom_range(1, 6);
      if (len == 1) begin
        byte_q.push_back(8'($urandom_range(0, 127)));
      end else begin
        nbits = 5 * len + 1;
        cp = $urandom & ((32'h1 << nbits) - 1);
        // dropping 5 bits puts the value under the floor for this length
        if ($urandom_range(9) == 0) cp = cp >> 5;
        lead = 8'(8'hFF << (8 - len)) | 8'(cp >> (6 * (len - 1)));
        byte_q.push_back(lead);
        for (k = len - 1; k > 0; k--)
          byte_q.push_back(8'h80 | 8'((cp >> (6 * (k - 1))) & 32'h3F));
      end
    end else if (pick < 80) begin
      // sequence cut short by a byte that is not a continuation
      len  = $urandom_range(2, 6);
      lead = 8'(8'hFF << (8 - len)) | 8'($urandom_range(0, (8'h7F >> len)));
      byte_q.push_back(lead);
      good = $urandom_range(0, len - 2);
      for (k = 0; k < good; k++) byte_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      if ($urandom_range(1) == 0) byte_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
      else                        byte_q.push_back(8'($urandom_range(8'hC0, 8'hFF)));
    end else if (pick < 88) begin
      byte_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 93) begin
      byte_q.push_back(8'($urandom_range(8'hFE, 8'hFF)));
    end else begin
      byte_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: random stall, plus the long hold-off when it is on.
  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Long receiver hold-off, timed here, while the sender keeps pushing
  // bytes so the block backs up and stalls its input.
  initial begin : squeeze_proc
    hold_off = 1'b0;
    wait (squeeze_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  // Result checker: every accepted word against the oldest expectation.
  always @(posedge clk_i) begin : check_out
    char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (want_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected word: cp %h err %0d", code_point_o, error_code_o);
      end else begin
        want = want_chars.pop_front();
        if (code_point_o !== want.cp || error_code_o !== want.err) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("mismatch: cp exp %h got %h, err exp %0d got %0d",
                     want.cp, code_point_o, want.err, error_code_o);
        end
      end
    end
  end

  initial begin : main_seq
    int unsigned phase, sent;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;

    // Directed bytes. Typed rows: ASCII extremes, stray continuations,
    // FE/FF, an overlong two-byte form and a broken trailing byte.
    dir_rows = '{
      '{8'h00, 1'b1, 31'h0000_0000, ERR_NONE},
      '{8'h7F, 1'b1, 31'h0000_007F, ERR_NONE},
      '{8'h80, 1'b1, 31'h0,         ERR_STRAY},
      '{8'hBF, 1'b1, 31'h0,         ERR_STRAY},
      '{8'hFE, 1'b1, 31'h0,         ERR_FEFF},
      '{8'hFF, 1'b1, 31'h0,         ERR_FEFF},
      // least two-byte value
      '{8'hC2, 1'b0, 31'h0,         ERR_NONE},
      '{8'h80, 1'b0, 31'h0,         ERR_NONE},
      // C0 80 is the overlong form of NUL
      '{8'hC0, 1'b0, 31'h0,         ERR_NONE},
      '{8'h80, 1'b1, 31'h0,         ERR_OVERLONG},
      // open three-byte sequence hit by ASCII: that byte is dropped
      '{8'hE0, 1'b0, 31'h0,         ERR_NONE},
      '{8'h41, 1'b1, 31'h0,         ERR_TRAIL},
      // largest six-byte value, all 31 bits set
      '{8'hFD, 1'b0, 31'h0,         ERR_NONE},
      '{8'hBF, 1'b0, 31'h0,         ERR_NONE},
      '{8'hBF, 1'b0, 31'h0,         ERR_NONE},
      '{8'hBF, 1'b0, 31'h0,         ERR_NONE},
      '{8'hBF, 1'b0, 31'h0,         ERR_NONE},
      '{8'hBF, 1'b0, 31'h0,         ERR_NONE},
      // five-byte sequence sitting exactly on its floor
      '{8'hF8, 1'b0, 31'h0,         ERR_NONE},
      '{8'h88, 1'b0, 31'h0,         ERR_NONE},
      '{8'h80, 1'b0, 31'h0,         ERR_NONE},
      '{8'h80, 1'b0, 31'h0,         ERR_NONE},
      '{8'h80, 1'b0, 31'h0,         ERR_NONE}
    };

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int unsigned i = 0; i < NUM_DIR; i++)
      send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].cp, dir_rows[i].err);

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 69; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 69; end
        default: begin send_gap_pct = 22; recv_stall_pct = 22; end
      endcase
      if (phase == 0) squeeze_go = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_chunk();
        while (byte_q.size() != 0) begin
          send_byte(byte_q.pop_front(), 1'b0, '0, ERR_NONE);
          sent++;
        end
      end
    end
    in_valid_i <= 1'b0;

    // Let every owed word arrive, then watch for strays a little longer.
    while (want_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) $display("== PASS ==");
    else                 $display("== FAIL ==");
    $finish;
  end

endmodule
